// ----- design/sstf_pkg.sv -----
// Shared types and constants of the SSTF disk request scheduler.
package sstf_pkg;

    localparam int SLOTS  = 8;
    localparam int BPR    = 8;
    localparam int BIW    = 16;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int POS_W  = $clog2(BPR);
    localparam int CNT_W  = $clog2(BPR + 1);
    localparam int PEND_W = $clog2(SLOTS + 1);
    localparam int ADDR_W = SLOT_W + POS_W;

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_FINISH = 2'd1;
    localparam logic [1:0] KIND_SERVE  = 2'd2;

    typedef enum logic [3:0] {
        ST_ADDED     = 4'd0,
        ST_INVALID   = 4'd1,
        ST_DUPLICATE = 4'd2,
        ST_LIST_FULL = 4'd3,
        ST_TBL_FULL  = 4'd4,
        ST_COMMITTED = 4'd5,
        ST_DISCARDED = 4'd6,
        ST_NONE      = 4'd7,
        ST_SERVED    = 4'd8
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE, S_DEC, S_SCAN, S_SHIFT, S_PUT, S_SRCH, S_EMIT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_SCAN, OP_SHIFT_INIT, OP_SHIFT, OP_PUT, OP_COMMIT,
        OP_RESP, OP_SRCH, OP_EMIT_INIT, OP_EMIT, OP_REMOVE
    } t_op;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] block_index;
    } t_in;

    typedef struct packed {
        logic [3:0]  status;
        logic [2:0]  served_position;
        logic [15:0] served_block;
        logic        last_of_run;
    } t_out;

    typedef struct packed {
        t_op     op;
        t_status code;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       pend_full;
        logic       pend_zero;
        logic       cnt_full;
        logic       idx_zero;
        logic       open_empty;
        logic       dup;
        logic       lt_eq_n;
        logic       scan_done;
        logic       srch_done;
        logic       iss_done;
    } t_stat;

endpackage

// ----- design/sstf_ctl.sv -----
// Sequencing state machine of the SSTF scheduler.
module sstf_ctl
    import sstf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = OP_NONE;
        o_cmd.code = ST_ADDED;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DEC;
                end
            end
            S_DEC: begin
                n_state = S_IDLE;
                priority if (i_stat.kind == KIND_ADD) begin
                    priority if (i_stat.pend_full) begin
                        o_cmd.op = OP_RESP; o_cmd.code = ST_TBL_FULL;
                    end else if (i_stat.cnt_full) begin
                        o_cmd.op = OP_RESP; o_cmd.code = ST_LIST_FULL;
                    end else if (i_stat.idx_zero) begin
                        o_cmd.op = OP_RESP; o_cmd.code = ST_INVALID;
                    end else if (i_stat.open_empty) begin
                        n_state = S_PUT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end else if (i_stat.kind == KIND_FINISH) begin
                    priority if (i_stat.pend_full) begin
                        o_cmd.op = OP_RESP; o_cmd.code = ST_TBL_FULL;
                    end else if (i_stat.open_empty) begin
                        o_cmd.op = OP_RESP; o_cmd.code = ST_DISCARDED;
                    end else begin
                        o_cmd.op = OP_COMMIT;
                    end
                end else if (i_stat.kind == KIND_SERVE) begin
                    if (i_stat.pend_zero) begin
                        o_cmd.op = OP_RESP; o_cmd.code = ST_NONE;
                    end else begin
                        n_state = S_SRCH;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                o_cmd.op = OP_SCAN;
                if (i_stat.scan_done) begin
                    priority if (i_stat.dup) begin
                        o_cmd.op = OP_RESP; o_cmd.code = ST_DUPLICATE;
                        n_state  = S_IDLE;
                    end else if (i_stat.lt_eq_n) begin
                        o_cmd.op = OP_NONE;
                        n_state  = S_PUT;
                    end else begin
                        o_cmd.op = OP_SHIFT_INIT;
                        n_state  = S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                o_cmd.op = OP_SHIFT;
                if (i_stat.iss_done && i_stat.scan_done) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                o_cmd.op = OP_PUT;
                n_state  = S_IDLE;
            end
            S_SRCH: begin
                o_cmd.op = OP_SRCH;
                if (i_stat.srch_done) begin
                    o_cmd.op = OP_EMIT_INIT;
                    n_state  = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.op = OP_EMIT;
                if (i_stat.iss_done && i_stat.scan_done) begin
                    o_cmd.op = OP_REMOVE;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ----- design/sstf_dp.sv -----
// Datapath of the SSTF scheduler: block store, slot map, counts and result register.
module sstf_dp
    import sstf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_in   i_in,
    input  t_cmd  i_cmd,
    output t_stat o_stat,
    output logic  o_res_valid,
    output t_out  o_res
);

    logic [BIW-1:0]    r_mem [SLOTS*BPR];
    logic [BIW-1:0]    r_rdata;
    logic [SLOT_W-1:0] r_map [SLOTS];
    logic [CNT_W-1:0]  r_cnt [SLOTS];
    logic [PEND_W-1:0] r_pend;
    logic [BIW-1:0]    r_last;
    logic [BIW-1:0]    r_idx;
    logic [1:0]        r_kind;
    logic [CNT_W-1:0]  r_j;
    logic [CNT_W-1:0]  r_lt;
    logic              r_dup;
    logic              r_iss;
    logic              r_rv;
    logic [POS_W-1:0]  r_rtag;
    logic [SLOT_W-1:0] r_best;
    logic [BIW-1:0]    r_bd;
    logic              r_o_valid;
    t_out              r_o_res;

    logic [SLOT_W-1:0] w_open;
    logic [CNT_W-1:0]  w_n_open;
    logic [CNT_W-1:0]  w_n_best;
    logic [POS_W-1:0]  w_best_last;
    logic              w_rd_en;
    logic [ADDR_W-1:0] w_rd_addr;
    logic              w_wr_en;
    logic [ADDR_W-1:0] w_wr_addr;
    logic [BIW-1:0]    w_wr_data;
    logic [BIW-1:0]    w_dist;
    logic [SLOT_W-1:0] w_rslot;
    logic              w_o_valid;

    assign w_open      = r_pend[SLOT_W-1:0];
    assign w_n_open    = r_cnt[w_open];
    assign w_n_best    = r_cnt[r_best];
    assign w_best_last = POS_W'(w_n_best - CNT_W'(1));
    assign w_rslot     = r_j[SLOT_W-1:0];
    assign w_dist      = (r_rdata >= r_last) ? (r_rdata - r_last) : (r_last - r_rdata);
    assign w_o_valid   = (i_cmd.op == OP_PUT) || (i_cmd.op == OP_COMMIT) ||
                         (i_cmd.op == OP_RESP) || ((i_cmd.op == OP_EMIT) && r_rv);

    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = '0;
        unique case (i_cmd.op)
            OP_SCAN: begin
                w_rd_en   = (r_j < w_n_open);
                w_rd_addr = {r_map[w_open], r_j[POS_W-1:0]};
            end
            OP_SHIFT: begin
                w_rd_en   = !r_iss;
                w_rd_addr = {r_map[w_open], r_j[POS_W-1:0]};
            end
            OP_SRCH: begin
                w_rd_en   = (PEND_W'(r_j) < r_pend);
                w_rd_addr = {r_map[w_rslot], POS_W'(0)};
            end
            OP_EMIT: begin
                w_rd_en   = !r_iss;
                w_rd_addr = {r_map[r_best], r_j[POS_W-1:0]};
            end
            default: begin
                w_rd_en   = 1'b0;
                w_rd_addr = '0;
            end
        endcase
    end

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = {r_map[w_open], r_lt[POS_W-1:0]};
        w_wr_data = r_idx;
        if (i_cmd.op == OP_SHIFT && r_rv) begin
            w_wr_en   = 1'b1;
            w_wr_addr = {r_map[w_open], POS_W'(r_rtag + POS_W'(1))};
            w_wr_data = r_rdata;
        end else if (i_cmd.op == OP_PUT) begin
            w_wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < SLOTS; r++) begin
                r_map[r] <= SLOT_W'(r);
                r_cnt[r] <= '0;
            end
            r_pend    <= '0;
            r_last    <= '0;
            r_idx     <= '0;
            r_kind    <= '0;
            r_j       <= '0;
            r_lt      <= '0;
            r_dup     <= 1'b0;
            r_iss     <= 1'b0;
            r_rv      <= 1'b0;
            r_rtag    <= '0;
            r_best    <= '0;
            r_bd      <= '0;
            r_o_valid <= 1'b0;
            r_o_res   <= '0;
        end else begin
            r_o_valid <= w_o_valid;
            r_rv      <= w_rd_en;
            if (w_rd_en) begin
                r_rtag <= r_j[POS_W-1:0];
            end
            unique case (i_cmd.op)
                OP_LOAD: begin
                    r_idx  <= i_in.block_index;
                    r_kind <= i_in.kind;
                    r_j    <= '0;
                    r_lt   <= '0;
                    r_dup  <= 1'b0;
                    r_iss  <= 1'b0;
                end
                OP_SCAN: begin
                    if (w_rd_en) begin
                        r_j <= r_j + CNT_W'(1);
                    end
                    if (r_rv) begin
                        if (r_rdata < r_idx) begin
                            r_lt <= r_lt + CNT_W'(1);
                        end
                        if (r_rdata == r_idx) begin
                            r_dup <= 1'b1;
                        end
                    end
                end
                OP_SHIFT_INIT: begin
                    r_j   <= w_n_open - CNT_W'(1);
                    r_iss <= 1'b0;
                end
                OP_SHIFT: begin
                    if (!r_iss) begin
                        if (r_j[POS_W-1:0] == r_lt[POS_W-1:0]) begin
                            r_iss <= 1'b1;
                        end else begin
                            r_j <= r_j - CNT_W'(1);
                        end
                    end
                end
                OP_PUT: begin
                    r_cnt[w_open] <= w_n_open + CNT_W'(1);
                    r_o_res       <= '{status: ST_ADDED, served_position: '0,
                                       served_block: '0, last_of_run: 1'b1};
                end
                OP_COMMIT: begin
                    r_pend  <= r_pend + PEND_W'(1);
                    r_o_res <= '{status: ST_COMMITTED, served_position: '0,
                                 served_block: '0, last_of_run: 1'b1};
                end
                OP_RESP: begin
                    r_o_res <= '{status: i_cmd.code, served_position: '0,
                                 served_block: '0, last_of_run: 1'b1};
                end
                OP_SRCH: begin
                    if (w_rd_en) begin
                        r_j <= r_j + CNT_W'(1);
                    end
                    if (r_rv && (r_rtag == '0 || w_dist < r_bd)) begin
                        r_bd   <= w_dist;
                        r_best <= SLOT_W'(r_rtag);
                    end
                end
                OP_EMIT_INIT: begin
                    r_j   <= '0;
                    r_iss <= 1'b0;
                end
                OP_EMIT: begin
                    if (!r_iss) begin
                        r_iss <= (r_j[POS_W-1:0] == w_best_last);
                        r_j   <= r_j + CNT_W'(1);
                    end
                    if (r_rv) begin
                        r_o_res <= '{status: ST_SERVED, served_position: 3'(r_best),
                                     served_block: r_rdata,
                                     last_of_run: (r_rtag == w_best_last)};
                        if (r_rtag == w_best_last) begin
                            r_last <= r_rdata;
                        end
                    end
                end
                OP_REMOVE: begin
                    for (int r = 0; r < SLOTS - 1; r++) begin
                        if (SLOT_W'(r) >= r_best) begin
                            r_map[r] <= r_map[r+1];
                            r_cnt[r] <= r_cnt[r+1];
                        end
                    end
                    r_map[SLOTS-1] <= r_map[r_best];
                    r_cnt[SLOTS-1] <= '0;
                    r_pend         <= r_pend - PEND_W'(1);
                end
                default: begin
                end
            endcase
        end
    end

    assign o_stat.kind       = r_kind;
    assign o_stat.pend_full  = (r_pend >= PEND_W'(SLOTS));
    assign o_stat.pend_zero  = (r_pend == '0);
    assign o_stat.cnt_full   = (w_n_open >= CNT_W'(BPR));
    assign o_stat.idx_zero   = (r_idx == '0);
    assign o_stat.open_empty = (w_n_open == '0);
    assign o_stat.dup        = r_dup;
    assign o_stat.lt_eq_n    = (r_lt == w_n_open);
    assign o_stat.scan_done  = ((r_j >= w_n_open) || r_iss) && !r_rv;
    assign o_stat.srch_done  = (PEND_W'(r_j) >= r_pend) && !r_rv;
    assign o_stat.iss_done   = r_iss;

    assign o_res_valid = r_o_valid;
    assign o_res       = r_o_res;

endmodule

// ----- design/sstf_disk_request_scheduler_core.sv -----
// Top level of the SSTF disk request scheduler.
// Commands are taken when i_start is high and o_busy low; each result shows
// for one cycle with o_res_valid and cannot be held off. An accepted add to a
// non-empty request runs a read scan and, unless the new block sorts last,
// a shift pass over the block store (one read and one write port); serve
// with requests pending does one store read per cycle for the nearest-first
// search and then puts one block out per cycle.
module sstf_disk_request_scheduler_core
    import sstf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_in  i_cmd,
    output logic o_busy,
    output logic o_res_valid,
    output t_out o_res
);

    t_cmd  w_cmd;
    t_stat w_stat;

    sstf_ctl u_ctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (o_busy)
    );

    sstf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_cmd),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

endmodule

// ----- design/sstf_checker.sv -----
// Port-level assertions for the SSTF scheduler, bound to the top level.
module sstf_checker
    import sstf_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_res_valid,
    input t_out o_res
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |=> o_busy)
        else $error("accepted transaction did not raise busy");

    a_run_contig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res.last_of_run |=> o_res_valid && o_res.status == ST_SERVED)
        else $error("served run broken");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.status != ST_SERVED |-> o_res.last_of_run && !o_busy)
        else $error("single-result transaction malformed");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.status != ST_SERVED
        |-> o_res.served_block == '0 && o_res.served_position == '0)
        else $error("non-serve result carries serve fields");

endmodule

bind sstf_disk_request_scheduler_core sstf_checker u_sstf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .o_res_valid (o_res_valid),
    .o_res       (o_res)
);

// ----- bench/sstf_disk_request_scheduler_core_tb.sv -----
// Self-checking testbench for the SSTF disk request scheduler core.
`timescale 1ns / 1ps

module sstf_disk_request_scheduler_core_tb;
    import sstf_pkg::*;

    class sstf_scoreboard;
        logic [15:0] blocks [SLOTS][BPR];
        int          counts [SLOTS];
        int          pending;
        logic [15:0] last_read;
        t_out        expected_q[$];
        int          errors;

        function new();
            pending = 0;
            last_read = '0;
            errors = 0;
            foreach (counts[i]) counts[i] = 0;
        endfunction

        function void push(t_status st, int pos, logic [15:0] blk, bit last);
            t_out r;
            r.status = st;
            r.served_position = pos[2:0];
            r.served_block = blk;
            r.last_of_run = last;
            expected_q.push_back(r);
        endfunction

        function t_status add_block(logic [15:0] idx);
            int n, p;
            if (pending >= SLOTS) return ST_TBL_FULL;
            n = counts[pending];
            if (n >= BPR) return ST_LIST_FULL;
            if (idx == 0) return ST_INVALID;
            p = 0;
            while (p < n && blocks[pending][p] < idx) p++;
            if (p < n && blocks[pending][p] == idx) return ST_DUPLICATE;
            for (int i = n; i > p; i--) blocks[pending][i] = blocks[pending][i - 1];
            blocks[pending][p] = idx;
            counts[pending] = n + 1;
            return ST_ADDED;
        endfunction

        function void note_command(t_in c);
            int best, top, n;
            int bd, d;
            case (c.kind)
                KIND_ADD: push(add_block(c.block_index), 0, 16'd0, 1'b1);
                KIND_FINISH: begin
                    if (pending >= SLOTS) push(ST_TBL_FULL, 0, 16'd0, 1'b1);
                    else if (counts[pending] > 0) begin
                        pending++;
                        if (pending < SLOTS) counts[pending] = 0;
                        push(ST_COMMITTED, 0, 16'd0, 1'b1);
                    end else push(ST_DISCARDED, 0, 16'd0, 1'b1);
                end
                KIND_SERVE: begin
                    if (pending == 0) push(ST_NONE, 0, 16'd0, 1'b1);
                    else begin
                        best = 0;
                        bd = blocks[0][0] >= last_read ? blocks[0][0] - last_read
                                                       : last_read - blocks[0][0];
                        for (int r = 1; r < pending && r < SLOTS; r++) begin
                            d = blocks[r][0] >= last_read ? blocks[r][0] - last_read
                                                          : last_read - blocks[r][0];
                            if (d < bd) begin
                                bd = d;
                                best = r;
                            end
                        end
                        n = counts[best];
                        for (int i = 0; i < n; i++)
                            push(ST_SERVED, best, blocks[best][i], i + 1 == n);
                        if (n > 0) last_read = blocks[best][n - 1];
                        top = pending < SLOTS ? pending : SLOTS - 1;
                        for (int r = best; r < top; r++) begin
                            blocks[r] = blocks[r + 1];
                            counts[r] = counts[r + 1];
                        end
                        counts[top] = 0;
                        pending--;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_out got);
            t_out e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got.status !== e.status || got.served_position !== e.served_position ||
                got.served_block !== e.served_block || got.last_of_run !== e.last_of_run) begin
                $display("%0t: expected %0d/%0d/%h/%b actual %0d/%0d/%h/%b",
                         $time, e.status, e.served_position, e.served_block, e.last_of_run,
                         got.status, got.served_position, got.served_block, got.last_of_run);
                errors++;
            end
        endfunction
    endclass

    logic i_clk, i_rst_n, i_start;
    t_in  i_cmd;
    logic o_busy, o_res_valid;
    t_out o_res;
    sstf_scoreboard sb;
    int   idle_pct;
    longint cycles;
    bit   took;

    sstf_disk_request_scheduler_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_cmd(i_cmd),
        .o_busy(o_busy), .o_res_valid(o_res_valid), .o_res(o_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        took = 1'b0;
        if (i_rst_n && o_res_valid) sb.check_result(o_res);
        if (i_rst_n && i_start && !o_busy) begin
            sb.note_command(i_cmd);
            took = 1'b1;
        end
        cycles++;
        if (cycles > 400000) begin
            $display("sstf_disk_request_scheduler_core_tb NOT OK");
            $finish;
        end
    end

    task automatic send(logic [1:0] kind, logic [15:0] idx);
        while ($urandom_range(99) < idle_pct) @(negedge i_clk);
        i_start = 1'b1;
        i_cmd.kind = kind;
        i_cmd.block_index = idx;
        @(negedge i_clk);
        while (!took) @(negedge i_clk);
        i_start = 1'b0;
        i_cmd = 18'($urandom);
    endtask

    task automatic random_phase(int count);
        int r;
        logic [15:0] b;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            b = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(40));
            if ($urandom_range(15) == 0) b = 16'hFFFF;
            if (r < 60) send(KIND_ADD, b);
            else if (r < 78) send(KIND_FINISH, 16'($urandom));
            else if (r < 97) send(KIND_SERVE, 16'($urandom));
            else send(2'd3, 16'($urandom));
        end
    endtask

    initial begin
        sb = new();
        cycles = 0;
        idle_pct = 0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_cmd = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send(KIND_SERVE, 16'd0);
        send(KIND_FINISH, 16'd0);
        send(KIND_ADD, 16'd0);
        send(KIND_ADD, 16'hFFFF);
        send(KIND_ADD, 16'h0001);
        send(KIND_ADD, 16'hFFFF);
        send(KIND_ADD, 16'h8000);
        for (int i = 0; i < 6; i++) send(KIND_ADD, 16'(100 + 7 * i));
        send(KIND_ADD, 16'h0005);
        send(KIND_FINISH, 16'd0);
        send(KIND_ADD, 16'h0010);
        send(KIND_SERVE, 16'd0);
        send(KIND_FINISH, 16'd0);
        send(2'd3, 16'hFFFF);
        for (int s = 0; s < 8; s++) begin
            send(KIND_ADD, 16'(s * 3 + 1));
            send(KIND_FINISH, 16'd0);
        end
        send(KIND_ADD, 16'd9);
        send(KIND_FINISH, 16'd0);

        random_phase(65);
        idle_pct = 87;
        random_phase(65);
        idle_pct = 25;
        random_phase(65);
        idle_pct = 0;
        random_phase(30);

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("sstf_disk_request_scheduler_core_tb OK");
        else
            $display("sstf_disk_request_scheduler_core_tb NOT OK");
        $finish;
    end
endmodule

// ----- sstf_disk_request_scheduler_core.f -----
design/sstf_pkg.sv
design/sstf_ctl.sv
design/sstf_dp.sv
design/sstf_disk_request_scheduler_core.sv
design/sstf_checker.sv
bench/sstf_disk_request_scheduler_core_tb.sv
